// ===== rtl/sfd_pkg.sv =====
// Shared constants and types for the SBUS frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int FRAME_LENGTH = 25;
    localparam int STORED_BYTES = FRAME_LENGTH - 2;
    localparam int DATA_BYTES   = STORED_BYTES - 1;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 11;
    localparam int CH_IDX_W     = 4;
    localparam int FLAG_W       = 4;
    localparam int BYTE_W       = 8;
    localparam int DATA_W       = DATA_BYTES * BYTE_W;
    localparam int ASM_W        = STORED_BYTES * BYTE_W;
    localparam int POS_W        = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);
    localparam logic [POS_W-1:0] CLOSING_POS = POS_W'(FRAME_LENGTH - 1);

    localparam logic [CH_IDX_W-1:0] LAST_CHANNEL = CH_IDX_W'(NUM_CHANNELS - 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER_ALT = 2'd2;

    localparam logic [BYTE_W-1:0] START_MARKER_RST   = 8'd15;
    localparam logic [BYTE_W-1:0] END_MARKER_RST     = 8'd0;
    localparam logic [BYTE_W-1:0] END_MARKER_ALT_RST = 8'd4;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [DATA_W-1:0] data;
    } frame_t;

    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

endpackage

// ===== rtl/sfd_if.sv =====
// Handshake channel interfaces for received bytes and decoded channels.
`timescale 1ns / 1ps

interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        digital_ch17;
    logic        digital_ch18;
    logic        frame_lost;
    logic        failsafe_active;
    logic        last_channel;

    modport source (
        output valid, output channel_index, output channel_value,
        output digital_ch17, output digital_ch18, output frame_lost,
        output failsafe_active, output last_channel, input ready
    );
    modport sink (
        input valid, input channel_index, input channel_value,
        input digital_ch17, input digital_ch18, input frame_lost,
        input failsafe_active, input last_channel, output ready
    );
endinterface

// ===== rtl/sfd_front.sv =====
// Byte front end: hunts for the start byte, assembles the frame and checks the closing byte.
`timescale 1ns / 1ps

module sfd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    sfd_byte_if.sink                     rx,
    input  logic [sfd_pkg::BYTE_W-1:0]   start_marker,
    input  logic [sfd_pkg::BYTE_W-1:0]   end_marker,
    input  logic [sfd_pkg::BYTE_W-1:0]   end_marker_alt,
    input  logic                         queue_full,
    output sfd_pkg::frame_push_t         push
);

    logic [sfd_pkg::POS_W-1:0] pos_reg;
    logic [sfd_pkg::POS_W-1:0] pos_next;
    logic [sfd_pkg::ASM_W-1:0] asm_reg;
    logic [sfd_pkg::ASM_W-1:0] asm_next;
    logic                      accept;
    logic                      closing;
    logic                      end_match;

    assign closing   = (pos_reg == sfd_pkg::CLOSING_POS);
    assign rx.ready  = !(closing && queue_full);
    assign accept    = rx.valid && rx.ready;
    assign end_match = (rx.rx_byte == end_marker) || (rx.rx_byte == end_marker_alt);

    always_comb
    begin
        pos_next = pos_reg;
        asm_next = asm_reg;
        if (accept)
        begin
            if (pos_reg == sfd_pkg::POS_HUNT)
            begin
                if (rx.rx_byte == start_marker)
                begin
                    pos_next = sfd_pkg::POS_FIRST;
                end
            end
            else if (closing)
            begin
                pos_next = sfd_pkg::POS_HUNT;
            end
            else
            begin
                asm_next = {rx.rx_byte, asm_reg[sfd_pkg::ASM_W-1:sfd_pkg::BYTE_W]};
                pos_next = pos_reg + sfd_pkg::POS_W'(1);
            end
        end
    end

    assign push.push        = accept && closing && end_match;
    assign push.frame.data  = asm_reg[sfd_pkg::DATA_W-1:0];
    assign push.frame.flags = asm_reg[sfd_pkg::DATA_W +: sfd_pkg::FLAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= sfd_pkg::POS_HUNT;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
    end

    // The input only stalls while a closing byte waits for queue space.
    assert property (@(posedge clk) disable iff (!rst_n) !rx.ready |-> closing)
        else $error("Input stalled outside the closing byte position.");

    // A frame is never handed over when the queue has no room.
    assert property (@(posedge clk) disable iff (!rst_n) push.push |-> !queue_full)
        else $error("Frame pushed into a full queue.");

endmodule

// ===== rtl/sfd_queue.sv =====
// Short frame queue between the byte front end and the channel back end.
`timescale 1ns / 1ps

module sfd_queue #(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfd_pkg::frame_push_t push,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output sfd_pkg::frame_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    sfd_pkg::frame_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.frame;
        end
    end

    // A pop is only requested when a frame is present.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Pop from an empty frame queue.");

endmodule

// ===== rtl/sfd_back.sv =====
// Channel back end: unpacks one 11-bit channel per item from a queued frame.
`timescale 1ns / 1ps

module sfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  sfd_pkg::frame_t  head,
    output logic             pop,
    sfd_chan_if.source       chan
);

    logic                           active_reg;
    logic [sfd_pkg::CH_IDX_W-1:0]   cnt_reg;
    logic [sfd_pkg::DATA_W-1:0]     bits_reg;
    logic [sfd_pkg::FLAG_W-1:0]     flags_reg;
    logic                           take;
    logic                           is_last;

    assign pop     = !active_reg && !queue_empty;
    assign take    = chan.valid && chan.ready;
    assign is_last = (cnt_reg == sfd_pkg::LAST_CHANNEL);

    assign chan.valid           = active_reg;
    assign chan.channel_index   = cnt_reg;
    assign chan.channel_value   = bits_reg[sfd_pkg::CHAN_W-1:0];
    assign chan.digital_ch17    = flags_reg[0];
    assign chan.digital_ch18    = flags_reg[1];
    assign chan.frame_lost      = flags_reg[2];
    assign chan.failsafe_active = flags_reg[3];
    assign chan.last_channel    = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (pop)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg + sfd_pkg::CH_IDX_W'(1);
            if (is_last)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bits_reg  <= head.data;
            flags_reg <= head.flags;
        end
        else if (take)
        begin
            bits_reg <= bits_reg >> sfd_pkg::CHAN_W;
        end
    end

    // Taking the last channel ends the frame.
    assert property (@(posedge clk) disable iff (!rst_n) take && is_last |=> !chan.valid)
        else $error("Results continue after the last channel of a frame.");

    // Each frame starts its results at channel zero.
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> chan.valid && cnt_reg == '0)
        else $error("New frame does not start at channel zero.");

endmodule

// ===== rtl/sbus_frame_decoder_unit.sv =====
// Top level of the SBUS frame decoder: configuration registers and the three stages.
`timescale 1ns / 1ps

// Takes one received byte per item and, for every 25-byte frame whose closing byte matches
// either end marker, gives 16 items, one per channel, in order 0 to 15 with the flag bits on
// each and last_channel set on channel 15. Bad frames give nothing. A byte is accepted every
// cycle; the input stalls only when a closing byte arrives while all QUEUE_DEPTH queue slots
// hold frames not yet drained. Results leave at one per cycle while the sink is ready, 16
// per frame, pausing between frames while the back end loads the next one from the queue.
// When the queue and the back end are idle, a frame enters the queue as its closing byte
// is accepted, then moves into the back end, which offers its first result.
// Configuration writes take effect at once; register indexes beyond the list are ignored.
module sbus_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sfd_byte_if.sink                       rx,
    sfd_chan_if.source                     chan,
    input  logic                           cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]     cfg_wdata
);

    logic [sfd_pkg::BYTE_W-1:0] start_marker_reg;
    logic [sfd_pkg::BYTE_W-1:0] end_marker_reg;
    logic [sfd_pkg::BYTE_W-1:0] end_marker_alt_reg;
    sfd_pkg::frame_push_t       push;
    sfd_pkg::frame_t            head;
    logic                       queue_full;
    logic                       queue_empty;
    logic                       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg   <= sfd_pkg::START_MARKER_RST;
            end_marker_reg     <= sfd_pkg::END_MARKER_RST;
            end_marker_alt_reg <= sfd_pkg::END_MARKER_ALT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_START_MARKER:   start_marker_reg   <= cfg_wdata;
                sfd_pkg::CFG_END_MARKER:     end_marker_reg     <= cfg_wdata;
                sfd_pkg::CFG_END_MARKER_ALT: end_marker_alt_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    sfd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx),
        .start_marker   (start_marker_reg),
        .end_marker     (end_marker_reg),
        .end_marker_alt (end_marker_alt_reg),
        .queue_full     (queue_full),
        .push           (push)
    );

    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .empty (queue_empty),
        .head  (head)
    );

    sfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .chan        (chan)
    );

endmodule

// ===== bench/sfd_channel_checker.sv =====
// Checker that predicts the decoded channel items of the SBUS frame decoder and compares them.
`timescale 1ns / 1ps

module sfd_channel_checker
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sfd_byte_if                  rx,
    sfd_chan_if                  chan,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    output int                   fail_count,
    output int                   expected_left
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_IDX_W-1:0] index;
        logic [CHAN_W-1:0]   value;
        logic                ch17;
        logic                ch18;
        logic                lost;
        logic                failsafe;
        logic                last;
    } channel_result_t;

    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] frame_store [STORED_BYTES];
    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] end_reg;
    logic [BYTE_W-1:0] end_alt_reg;
    channel_result_t   expected_channels [$];
    channel_result_t   seen;
    int                channels_seen;

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [DATA_W-1:0] packed_bits;
        channel_result_t   r;
        if (frame_pos == POS_HUNT)
        begin
            if (b == start_reg)
                frame_pos = POS_FIRST;
        end
        else if (frame_pos < CLOSING_POS)
        begin
            frame_store[frame_pos - POS_FIRST] = b;
            frame_pos = frame_pos + POS_W'(1);
        end
        else
        begin
            frame_pos = POS_HUNT;
            if (b == end_reg || b == end_alt_reg)
            begin
                for (int i = 0; i < DATA_BYTES; i++)
                    packed_bits[i*BYTE_W +: BYTE_W] = frame_store[i];
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                begin
                    r.index    = CH_IDX_W'(ch);
                    r.value    = packed_bits[ch*CHAN_W +: CHAN_W];
                    r.ch17     = frame_store[STORED_BYTES-1][0];
                    r.ch18     = frame_store[STORED_BYTES-1][1];
                    r.lost     = frame_store[STORED_BYTES-1][2];
                    r.failsafe = frame_store[STORED_BYTES-1][3];
                    r.last     = (ch == NUM_CHANNELS - 1);
                    expected_channels.push_back(r);
                end
            end
        end
    endtask

    task automatic check_channel(input channel_result_t got);
        channel_result_t want;
        channels_seen++;
        if (expected_channels.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("channel item %0d arrived with nothing expected: idx %0d val %0d",
                         channels_seen, got.index, got.value);
        end
        else
        begin
            want = expected_channels.pop_front();
            if (got.index !== want.index || got.value !== want.value ||
                got.ch17 !== want.ch17 || got.ch18 !== want.ch18 ||
                got.lost !== want.lost || got.failsafe !== want.failsafe ||
                got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("channel item %0d: expected idx %0d val %0d flags %b last %b, %s",
                             channels_seen, want.index, want.value,
                             {want.failsafe, want.lost, want.ch18, want.ch17}, want.last,
                             $sformatf("got idx %0d val %0d flags %b last %b",
                                       got.index, got.value,
                                       {got.failsafe, got.lost, got.ch18, got.ch17}, got.last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos     = POS_HUNT;
            start_reg     = START_MARKER_RST;
            end_reg       = END_MARKER_RST;
            end_alt_reg   = END_MARKER_ALT_RST;
            channels_seen = 0;
            expected_channels.delete();
            expected_left = 0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                decode_byte(rx.rx_byte);
            if (chan.valid && chan.ready)
            begin
                seen.index    = chan.channel_index;
                seen.value    = chan.channel_value;
                seen.ch17     = chan.digital_ch17;
                seen.ch18     = chan.digital_ch18;
                seen.lost     = chan.frame_lost;
                seen.failsafe = chan.failsafe_active;
                seen.last     = chan.last_channel;
                check_channel(seen);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_MARKER:   start_reg = cfg_wdata;
                    CFG_END_MARKER:     end_reg = cfg_wdata;
                    CFG_END_MARKER_ALT: end_alt_reg = cfg_wdata;
                    default: ;
                endcase
            end
            expected_left = expected_channels.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the SBUS frame decoder bench: clock, reset, byte and marker stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
    import sfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int BYTES_PER_PHASE = 6;
    localparam int MAX_GAP         = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;
    logic [BYTE_W-1:0]    start_mark = START_MARKER_RST;
    logic [BYTE_W-1:0]    end_mark = END_MARKER_RST;
    logic [BYTE_W-1:0]    end_alt_mark = END_MARKER_ALT_RST;
    logic [BYTE_W-1:0]    payload [STORED_BYTES];
    bit                   src_steady;
    bit                   sink_steady;
    int                   quiet_cycles;
    int                   fail_count;
    int                   expected_left;

    sfd_byte_if rx_if ();
    sfd_chan_if chan_if ();

    sbus_frame_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .chan      (chan_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sfd_channel_checker channel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_if),
        .chan          (chan_if),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #1 clk = ~clk;

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 23) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        @(negedge clk);
    endtask

    // The closing byte is sent only when the whole body was sent.
    task automatic send_frame(input int stored, input logic [BYTE_W-1:0] close);
        send_byte(start_mark);
        for (int i = 0; i < stored; i++)
            send_byte(payload[i]);
        if (stored == STORED_BYTES)
            send_byte(close);
    endtask

    function automatic logic [BYTE_W-1:0] pick_closing(input bit good);
        logic [BYTE_W-1:0] v;
        if (good)
            v = $urandom_range(0, 1) ? end_mark : end_alt_mark;
        else
        begin
            v = BYTE_W'($urandom);
            while (v == end_mark || v == end_alt_mark)
                v = v + 8'd1;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_filler();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom);
        while (v == start_mark || v == end_mark || v == end_alt_mark)
            v = v + 8'd1;
        return v;
    endfunction

    task automatic settle();
        rx_if.valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                                input logic [BYTE_W-1:0] a, input bit touch_unused);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_MARKER;
        cfg_wdata <= s;
        @(negedge clk);
        cfg_index <= CFG_END_MARKER;
        cfg_wdata <= e;
        @(negedge clk);
        cfg_index <= CFG_END_MARKER_ALT;
        cfg_wdata <= a;
        if (touch_unused)
        begin
            @(negedge clk);
            cfg_index <= CFG_UNUSED_INDEX;
            cfg_wdata <= BYTE_W'($urandom);
        end
        @(negedge clk);
        cfg_we       <= 1'b0;
        start_mark   = s;
        end_mark     = e;
        end_alt_mark = a;
    endtask

    // Mostly whole frames with random content, some with a bad closing byte,
    // some cut short, and some loose bytes between them.
    task automatic run_phase(input int budget);
        int sent;
        int pick;
        int cut;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            foreach (payload[i])
                payload[i] = BYTE_W'($urandom);
            if (pick < 70)
            begin
                send_frame(STORED_BYTES, pick_closing(1'b1));
                sent += FRAME_LENGTH;
            end
            else if (pick < 80)
            begin
                send_frame(STORED_BYTES, pick_closing(1'b0));
                sent += FRAME_LENGTH;
            end
            else if (pick < 88)
            begin
                cut = $urandom_range(0, STORED_BYTES - 1);
                send_frame(cut, '0);
                sent += cut + 1;
            end
            else
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
        end
        repeat (FRAME_LENGTH) send_byte(pick_filler());
        settle();
    endtask

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 23) == 0)
                sink_steady = !sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                chan_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            chan_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!chan_if.valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (chan_if.valid && chan_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_MARKER;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        chan_if.ready = 1'b0;
        quiet_cycles  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Loose bytes while hunting, including an end marker value.
        send_byte(8'h00);
        send_byte(8'hFF);
        foreach (payload[i])
            payload[i] = 8'hFF;
        send_frame(STORED_BYTES, end_mark);
        foreach (payload[i])
            payload[i] = 8'h00;
        send_frame(STORED_BYTES, end_alt_mark);
        // Marker values inside the body are plain data; a closing byte equal to the
        // start marker drops the frame and does not open a new one.
        foreach (payload[i])
            payload[i] = (i % 3 == 0) ? start_mark : ((i % 3 == 1) ? end_mark : end_alt_mark);
        payload[STORED_BYTES-1] = 8'h0A;
        send_frame(STORED_BYTES, start_mark);
        foreach (payload[i])
            payload[i] = BYTE_W'($urandom);
        send_frame(STORED_BYTES, end_mark);
        run_phase(BYTES_PER_PHASE);

        // Both end markers equal.
        load_markers(8'h00, 8'hFF, 8'hFF, 1'b1);
        foreach (payload[i])
            payload[i] = BYTE_W'($urandom);
        send_frame(STORED_BYTES, end_mark);
        run_phase(BYTES_PER_PHASE);

        load_markers(8'hFF, 8'h00, 8'h80, 1'b0);
        run_phase(BYTES_PER_PHASE);

        load_markers(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
        run_phase(BYTES_PER_PHASE);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/sbus_frame_decoder_unit.sv
bench/sfd_channel_checker.sv
bench/testbench.sv
